[rtl/core/fct_pkg.sv]
// Package for the frustum cull test core: widths, op codes, plane fields.
// No dependencies; used by every file in rtl/core.
`default_nettype none
package fct_pkg;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int NUM_PLANES = 6;
  localparam int PLANE_W = 64;
  localparam int NORM_W = 16;
  localparam int IDX_W = 3;
  localparam int ALIGN_SHIFT = 14;

  typedef enum logic [1:0] {
    OP_POINT  = 2'd0,
    OP_SPHERE = 2'd1,
    OP_BOX    = 2'd2,
    OP_CUBE   = 2'd3
  } op_t;

  typedef logic [PLANE_W-1:0] plane_t;
endpackage
`default_nettype wire

[rtl/core/fct_if.sv]
// Valid/ready channel interfaces for the frustum cull test core.
// Depends on fct_pkg.
`default_nettype none
interface fct_in_if #(parameter int CW = fct_pkg::COORD_WIDTH_DEF);
  logic valid;
  logic ready;
  logic [1:0] op;
  logic signed [CW-1:0] pos_x;
  logic signed [CW-1:0] pos_y;
  logic signed [CW-1:0] pos_z;
  logic [CW-2:0] size_x;
  logic [CW-2:0] size_y;
  logic [CW-2:0] size_z;
  logic [CW-2:0] radius;
  modport source (output valid, op, pos_x, pos_y, pos_z, size_x, size_y, size_z, radius,
                  input ready);
  modport sink (input valid, op, pos_x, pos_y, pos_z, size_x, size_y, size_z, radius,
                output ready);
endinterface

interface fct_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

interface fct_cfg_if;
  logic valid;
  logic ready;
  logic [fct_pkg::IDX_W-1:0] index;
  logic [fct_pkg::PLANE_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/core/fct_plane_unit.sv]
// One plane's distance test, three register stages: products, sums, compare.
// Depends on fct_pkg. Advances when en is high.
`default_nettype none
module fct_plane_unit #(
  parameter int CW = fct_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire fct_pkg::plane_t       plane,
  input  wire logic [1:0]            op,
  input  wire logic signed [CW-1:0]  px,
  input  wire logic signed [CW-1:0]  py,
  input  wire logic signed [CW-1:0]  pz,
  input  wire logic [CW-2:0]         sx,
  input  wire logic [CW-2:0]         sy,
  input  wire logic [CW-2:0]         sz,
  input  wire logic [CW-2:0]         rad,
  output logic                       reject
);
  localparam int PW = fct_pkg::NORM_W + CW + 1;
  localparam int SW = PW + 4;

  logic signed [fct_pkg::NORM_W-1:0] a, b, c, d;
  logic [fct_pkg::NORM_W-1:0] aa, ab, ac;
  logic signed [PW-1:0] pa_r, pb_r, pc_r, ra_r, rb_r, rc_r, rd_r;
  logic [1:0] op1_r, op2_r;
  logic signed [SW-1:0] dist_r, reach_r, rr_r;
  logic signed [SW-1:0] dist_nxt, reach_nxt, rr_nxt, tot;
  logic reject_r, reject_nxt;

  assign a = plane[15:0];
  assign b = plane[31:16];
  assign c = plane[47:32];
  assign d = plane[63:48];
  assign aa = a[fct_pkg::NORM_W-1] ? fct_pkg::NORM_W'(-a) : fct_pkg::NORM_W'(a);
  assign ab = b[fct_pkg::NORM_W-1] ? fct_pkg::NORM_W'(-b) : fct_pkg::NORM_W'(b);
  assign ac = c[fct_pkg::NORM_W-1] ? fct_pkg::NORM_W'(-c) : fct_pkg::NORM_W'(c);

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= PW'(a) * PW'(px);
      pb_r <= PW'(b) * PW'(py);
      pc_r <= PW'(c) * PW'(pz);
      ra_r <= PW'($signed({1'b0, aa})) * PW'($signed({1'b0, sx}));
      rb_r <= PW'($signed({1'b0, ab})) * PW'($signed({1'b0, sy}));
      rc_r <= PW'($signed({1'b0, ac})) * PW'($signed({1'b0, sz}));
      rd_r <= PW'($signed({1'b0, rad})) <<< fct_pkg::ALIGN_SHIFT;
      dist_r <= dist_nxt;
      reach_r <= reach_nxt;
      rr_r <= rr_nxt;
      op1_r <= op;
      op2_r <= op1_r;
      reject_r <= reject_nxt;
    end
  end

  // rd slot carries only the sphere radius; d is aligned in its own register and added here
  logic signed [SW-1:0] d_al_r;
  always_ff @(posedge clk) begin
    if (en) d_al_r <= SW'(d) <<< fct_pkg::ALIGN_SHIFT;
  end

  assign dist_nxt  = SW'(pa_r) + SW'(pb_r) + SW'(pc_r) + d_al_r;
  assign reach_nxt = SW'(ra_r) + SW'(rb_r) + SW'(rc_r);
  assign rr_nxt    = SW'(rd_r);
  assign tot       = dist_r + reach_r;

  always_comb begin
    case (op2_r)
      fct_pkg::OP_POINT:  reject_nxt = dist_r < 0;
      fct_pkg::OP_SPHERE: reject_nxt = dist_r <= -rr_r;
      default:            reject_nxt = tot <= 0;
    endcase
  end

  assign reject = reject_r;
endmodule
`default_nettype wire

[rtl/core/frustum_cull_test_core.sv]
// Top level of the six-plane frustum cull test: plane registers, pipeline, output.
// Depends on fct_pkg, fct_if interfaces and fct_plane_unit.
//
//  channel | dir | payload                                   | accept
//  in_     | in  | op, pos_x/y/z, size_x/y/z, radius         | valid & ready
//  out_    | out | inside_res                                | valid & ready
//  cfg_    | in  | index (0..5 planes), data (a,b,c,d packed) | valid & ready
//
// One object a cycle unless the output stalls; registers in order: products, sums, compare, AND of planes.
// The stall point is out_ready: the whole pipeline freezes together when the
// output register is full and not taken, so nothing is lost or repeated.
// Reset clears valid bits and zeroes all planes; cfg is always ready.
`default_nettype none
module frustum_cull_test_core #(
  parameter int COORD_WIDTH = fct_pkg::COORD_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  fct_in_if.sink    in_ch,
  fct_out_if.source out_ch,
  fct_cfg_if.sink   cfg_ch
);
  localparam int NP = fct_pkg::NUM_PLANES;

  fct_pkg::plane_t plane_r [NP];
  logic [3:0] vld_r;
  logic       res_r;
  logic       en;
  logic [NP-1:0] rej;

  // Advance whenever the output slot is free or being drained.
  assign en = !vld_r[3] || out_ch.ready;
  assign in_ch.ready = en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NP; i++) plane_r[i] <= '0;
    end else if (cfg_ch.valid && cfg_ch.index < fct_pkg::IDX_W'(NP)) begin
      plane_r[cfg_ch.index] <= cfg_ch.data;
    end
  end

  for (genvar g = 0; g < NP; g++) begin : g_plane
    fct_plane_unit #(.CW(COORD_WIDTH)) u_pl (
      .clk   (clk),
      .en    (en),
      .plane (plane_r[g]),
      .op    (in_ch.op),
      .px    (in_ch.pos_x),
      .py    (in_ch.pos_y),
      .pz    (in_ch.pos_z),
      .sx    (in_ch.size_x),
      .sy    ((in_ch.op == fct_pkg::OP_CUBE) ? in_ch.size_x : in_ch.size_y),
      .sz    ((in_ch.op == fct_pkg::OP_CUBE) ? in_ch.size_x : in_ch.size_z),
      .rad   (in_ch.radius),
      .reject(rej[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) res_r <= ~|rej;
  end

  assign out_ch.valid = vld_r[3];
  assign out_ch.inside_res = res_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.inside_res))
    else $error("result dropped during stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready) else $error("input blocked with empty output");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[0]) else $error("accepted item lost");
endmodule
`default_nettype wire
